>>> rtl/wsor_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsor_pkg: shared types and constants for the window sigma outlier filter
// Widths of the sample fields and of the fixed-point deviation arithmetic.
// ----------------------------------------------------------------------------
package wsor_pkg;

	localparam int WIN    = 5;   // samples in the window
	localparam int CTR    = 2;   // centre position, index WIN-1 is newest
	localparam int TAIL_N = 3;   // window positions that can be emitted
	localparam int TS_W   = 31;
	localparam int VAL_W  = 32;
	localparam int FILL_W = 3;
	localparam int SUM_W  = 35;  // sum of five 32-bit values
	localparam int DEV_W  = 36;  // 5*v - sum, signed
	localparam int MAG_W  = 35;  // |5*v - sum|
	localparam int SQ_W   = 2 * MAG_W;
	localparam int TOT_W  = SQ_W + 3;

	typedef logic [FILL_W-1:0]        fill_t;
	typedef logic [TS_W-1:0]          ts_t;
	typedef logic signed [VAL_W-1:0]  val_t;
	typedef val_t [WIN-1:0]           win_val_t;
	typedef ts_t  [WIN-1:0]           win_ts_t;
	typedef logic [MAG_W-1:0]         mag_t;
	typedef logic [SQ_W-1:0]          sq_t;
	typedef logic [TOT_W-1:0]         tot_t;

	localparam fill_t FILL_FULL   = fill_t'(WIN);
	localparam fill_t FILL_CENTRE = fill_t'(3);  // centre position holds a sample
	localparam fill_t FILL_PAIR   = fill_t'(2);  // next-to-newest holds a sample

	// one emittable sample
	typedef struct packed {
		ts_t  ts;
		val_t value;
	} smp_t;

	// positions CTR..WIN-1 of the window, entry 0 is the centre
	typedef smp_t [TAIL_N-1:0] tail_t;

	// control that travels with each pipeline beat
	typedef struct packed {
		logic  valid;
		fill_t fill;
		logic  last;
	} item_ctl_t;

	// which tail positions one item sends out, oldest in bit 0
	typedef struct packed {
		logic emit_newest;
		logic emit_next;
		logic keep_centre;
	} emit_mask_t;

	// Square a 35-bit magnitude as a 32x32 product plus narrow side terms.
	function automatic sq_t mag_square(mag_t mag);
		logic [31:0]        lo;
		logic [MAG_W-33:0]  hi;
		logic [63:0]        ll;
		logic [MAG_W-1:0]   hl;
		logic [5:0]         hh;
		lo = mag[31:0];
		hi = mag[MAG_W-1:32];
		ll = 64'(lo) * 64'(lo);
		hl = MAG_W'(hi) * MAG_W'(lo);
		hh = 6'(hi) * 6'(hi);
		return SQ_W'(ll) + (SQ_W'(hl) << 33) + (SQ_W'(hh) << 64);
	endfunction

endpackage
`default_nettype wire

>>> rtl/wsor_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsor_window: five-sample window and series fill tracking
// Shifts in each accepted sample and tags the beat with the fill level.
// ----------------------------------------------------------------------------
module wsor_window (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   adv,
	input  wire                   sample_valid,
	input  wsor_pkg::ts_t         sample_timestamp,
	input  wsor_pkg::val_t        sample_value,
	input  wire                   last_sample,
	output wsor_pkg::win_val_t    win_value,
	output wsor_pkg::win_ts_t     win_stamp,
	output wsor_pkg::item_ctl_t   ctl_s1
);
	import wsor_pkg::*;

	win_val_t  value_q;
	win_ts_t   stamp_q;
	fill_t     fill_q;
	fill_t     fill_next;
	logic      accept;

	assign accept    = sample_valid && adv;
	assign fill_next = (fill_q < FILL_FULL) ? fill_q + fill_t'(1) : FILL_FULL;

	// shift the window, newest at the top
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < WIN - 1; k++) begin
				value_q[k] <= value_q[k+1];
				stamp_q[k] <= stamp_q[k+1];
			end
			value_q[WIN-1] <= sample_value;
			stamp_q[WIN-1] <= sample_timestamp;
		end
	end

	// track fill, restart after the final sample of a series
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid <= sample_valid;
			if (sample_valid) begin
				ctl_s1.fill <= fill_next;
				ctl_s1.last <= last_sample;
				fill_q      <= last_sample ? '0 : fill_next;
			end
		end
	end

	assign win_value = value_q;
	assign win_stamp = stamp_q;

endmodule
`default_nettype wire

>>> rtl/wsor_sigma.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsor_sigma: one-sigma outlier test on the window centre
// Sum, deviations, squares and totals in four registered steps; the final
// compare decides which tail samples the beat sends out.
// ----------------------------------------------------------------------------
module wsor_sigma (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   adv,
	input  wsor_pkg::item_ctl_t   ctl_s1,
	input  wsor_pkg::win_val_t    win_value,
	input  wsor_pkg::win_ts_t     win_stamp,
	output logic                  item_valid,
	output wsor_pkg::emit_mask_t  item_mask,
	output wsor_pkg::tail_t       item_tail
);
	import wsor_pkg::*;

	item_ctl_t ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	tail_t     tail_s2, tail_s3, tail_s4, tail_s5;
	win_val_t  value_s2;
	logic signed [SUM_W-1:0] sum_s2;
	mag_t      mag_s3 [WIN];
	sq_t       sq_s4 [WIN];
	tot_t      total_s5;
	tot_t      ctr5_s5;

	logic signed [SUM_W-1:0] sum_d;
	logic signed [DEV_W-1:0] dev_d [WIN];
	tot_t      total_d;
	tail_t     tail_d;
	logic      reject;

	// gather the emittable positions from the window
	always_comb begin
		for (int k = 0; k < TAIL_N; k++) begin
			tail_d[k].ts    = win_stamp[CTR+k];
			tail_d[k].value = win_value[CTR+k];
		end
	end

	// window sum
	always_comb begin
		sum_d = '0;
		for (int k = 0; k < WIN; k++) begin
			sum_d = sum_d + SUM_W'(win_value[k]);
		end
	end

	// deviations 5*v - sum
	always_comb begin
		for (int k = 0; k < WIN; k++) begin
			dev_d[k] = (DEV_W'(value_s2[k]) <<< 2) + DEV_W'(value_s2[k]) - DEV_W'(sum_s2);
		end
	end

	// total of squared deviations
	always_comb begin
		total_d = '0;
		for (int k = 0; k < WIN; k++) begin
			total_d = total_d + TOT_W'(sq_s4[k]);
		end
	end

	// advance the control beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	// advance the datapath
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2   <= sum_d;
			value_s2 <= win_value;
			tail_s2  <= tail_d;
			for (int k = 0; k < WIN; k++) begin
				mag_s3[k] <= dev_d[k][DEV_W-1] ? MAG_W'(-dev_d[k]) : MAG_W'(dev_d[k]);
				sq_s4[k]  <= mag_square(mag_s3[k]);
			end
			tail_s3  <= tail_s2;
			tail_s4  <= tail_s3;
			total_s5 <= total_d;
			ctr5_s5  <= (TOT_W'(sq_s4[CTR]) << 2) + TOT_W'(sq_s4[CTR]);
			tail_s5  <= tail_s4;
		end
	end

	// drop the centre at or beyond one sigma; flush the tail on the last beat
	assign reject = ctr5_s5 >= total_s5;

	assign item_valid             = ctl_s5.valid;
	assign item_mask.keep_centre  = (ctl_s5.fill >= FILL_CENTRE)
		&& ((ctl_s5.fill != FILL_FULL) || !reject);
	assign item_mask.emit_next    = ctl_s5.last && (ctl_s5.fill >= FILL_PAIR);
	assign item_mask.emit_newest  = ctl_s5.last;
	assign item_tail              = tail_s5;

endmodule
`default_nettype wire

>>> rtl/wsor_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsor_emit: result sequencer and output register
// Sends the kept samples of each beat one per cycle while out_stall is low, oldest first.
// ----------------------------------------------------------------------------
module wsor_emit (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   item_valid,
	input  wsor_pkg::emit_mask_t  item_mask,
	input  wsor_pkg::tail_t       item_tail,
	output logic                  item_ready,
	output logic                  out_valid,
	input  wire                   out_stall,
	output wsor_pkg::ts_t         out_timestamp,
	output wsor_pkg::val_t        out_value,
	output logic                  out_last
);
	import wsor_pkg::*;

	logic [TAIL_N-1:0] pend_q;
	logic [TAIL_N-1:0] pend_left;
	tail_t             tail_q;
	logic              out_free;
	logic              send;
	smp_t              pick;
	logic              pick_last;

	assign out_free  = !out_valid || !out_stall;
	assign send      = out_free && (pend_q != '0);
	assign pend_left = send ? (pend_q & (pend_q - TAIL_N'(1))) : pend_q;
	assign item_ready = (pend_left == '0);

	// select the oldest pending sample
	always_comb begin
		if (pend_q[0]) begin
			pick      = tail_q[0];
			pick_last = 1'b0;
		end else if (pend_q[1]) begin
			pick      = tail_q[1];
			pick_last = 1'b0;
		end else begin
			pick      = tail_q[2];
			pick_last = 1'b1;
		end
	end

	// load a new beat once the previous one is drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				pend_q <= item_mask;
			end else begin
				pend_q <= pend_left;
			end
			if (out_free) begin
				out_valid <= send;
			end
		end
	end

	// hold the beat payload and the output register
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			tail_q <= item_tail;
		end
		if (send) begin
			out_timestamp <= pick.ts;
			out_value     <= pick.value;
			out_last      <= pick_last;
		end
	end

endmodule
`default_nettype wire

>>> rtl/window_sigma_outlier_reject.sv
`default_nettype none
// ----------------------------------------------------------------------------
// window_sigma_outlier_reject: five-sample sliding sigma outlier filter
// Top level: window, outlier test pipeline and result sequencer.
// ----------------------------------------------------------------------------
// Samples of a series enter one per cycle while sample_stall is low. Each
// sample from the third to the third-from-last is dropped when it lies at or
// beyond one standard deviation of the five-sample window around it (exact
// integer test, no square root); the first two and last two samples of a
// series always pass, and a series shorter than five passes unchanged. Kept
// samples leave two samples late in arrival order; the beat with last_sample
// set also flushes the two held samples, and the final kept sample carries
// out_last. The final sample of a series yields up to three results and holds
// the input while they are sent, since the output register sends one result
// per cycle while out_stall is low. From input to output a sample passes the
// window register, four test stages, the sequencer and the output register.
// ----------------------------------------------------------------------------
module window_sigma_outlier_reject (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              sample_valid,
	output logic             sample_stall,
	input  wsor_pkg::ts_t    sample_timestamp,
	input  wsor_pkg::val_t   sample_value,
	input  wire              last_sample,
	output logic             out_valid,
	input  wire              out_stall,
	output wsor_pkg::ts_t    out_timestamp,
	output wsor_pkg::val_t   out_value,
	output logic             out_last
);
	import wsor_pkg::*;

	logic        adv;
	item_ctl_t   ctl_s1;
	win_val_t    win_value;
	win_ts_t     win_stamp;
	logic        item_valid;
	emit_mask_t  item_mask;
	tail_t       item_tail;
	logic        item_ready;

	// move the whole pipeline unless the sequencer is still busy
	assign adv          = !item_valid || item_ready;
	assign sample_stall = !adv;

	wsor_window u_window (
		.clk              (clk),
		.arst_n           (arst_n),
		.adv              (adv),
		.sample_valid     (sample_valid),
		.sample_timestamp (sample_timestamp),
		.sample_value     (sample_value),
		.last_sample      (last_sample),
		.win_value        (win_value),
		.win_stamp        (win_stamp),
		.ctl_s1           (ctl_s1)
	);

	wsor_sigma u_sigma (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.ctl_s1     (ctl_s1),
		.win_value  (win_value),
		.win_stamp  (win_stamp),
		.item_valid (item_valid),
		.item_mask  (item_mask),
		.item_tail  (item_tail)
	);

	wsor_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_mask     (item_mask),
		.item_tail     (item_tail),
		.item_ready    (item_ready),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_timestamp (out_timestamp),
		.out_value     (out_value),
		.out_last      (out_last)
	);

endmodule
`default_nettype wire
